[src/s2cd_pkg.sv]
`default_nettype none

package s2cd_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;

  localparam int unsigned InW  = 32;
  localparam int unsigned OutW = 40;

  // Rounded-up reciprocals: x / 675 = (x * DayRecip) >> 35 for x < 2^25,
  // x / 225 = (x * HourRecip) >> 21 for x < 2^13, x / 15 = (x * MinRecip) >> 14
  // for x < 2^10.
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam logic [10:0] MinRecip  = 11'd1093;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [3:0] MonthDec = 4'd12;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic day_step;
    logic day_sub;
    logic year_step;
    logic month_step;
    logic hour_step;
    logic hour_sub;
    logic min_step;
    logic min_sub;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic year_done;
    logic month_done;
  } sts_t;

  // Years 2000..2255: only 2100 and 2200 are century years that are not leap.
  function automatic logic is_leap(logic [7:0] yr);
    return (yr[1:0] == 2'b00) && (yr != 8'd100) && (yr != 8'd200);
  endfunction

  function automatic logic [8:0] year_days(logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] mon, logic leap);
    logic [4:0] len;
    unique case (mon) inside
      MonthFeb:                               len = leap ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default:                                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[src/seconds_to_calendar_date.sv]
// Seconds-since-2000 to calendar date and time of day.
//
// Input stream: one transaction carries a 32-bit seconds count on s_axis_tdata_i.
// Output stream: one transaction per input carries year offset, month, day,
// hour, minute and second on m_axis_tdata_o.
//
// Conversion steps from input acceptance to m_axis_tvalid_o: split off whole
// days by reciprocal multiplication, walk the years, walk the months, derive
// hour and minute, then load the output register. One conversion is in flight
// at a time; a new input is taken the cycle after the previous result is
// loaded into the output register. The year walk is the longest step.
//
// Reset (rst_ni low, asynchronous) returns the controller to idle and drops
// any pending output. When the receiver stalls, the result holds in the output
// register and the next conversion runs up to its end, then waits for space.
`default_nettype none

module seconds_to_calendar_date
  import s2cd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid_i,
  output      logic            s_axis_tready_o,
  input  wire logic [InW-1:0]  s_axis_tdata_i,  // [31:0] epoch_seconds
  output      logic            m_axis_tvalid_o,
  input  wire logic            m_axis_tready_i,
  // [7:0] year_offset, [11:8] month_number, [16:12] day_of_month,
  // [21:17] hour_of_day, [27:22] minute_of_hour, [33:28] second_of_minute
  output      logic [OutW-1:0] m_axis_tdata_o
);

  cmd_t            cmd;
  sts_t            sts;
  logic [OutW-1:0] result;
  logic            out_free;
  logic            out_push;

  s2cd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .out_free_i (out_free),
    .out_push_o (out_push)
  );

  s2cd_dp u_dp (
    .clk_i     (clk_i),
    .in_data_i (s_axis_tdata_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .result_o  (result)
  );

  s2cd_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (out_push),
    .data_i          (result),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // a new conversion closes the input until its result is loaded into the output register
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while a conversion is in flight");

  a_push_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> out_free)
    else $error("result pushed over a held output");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:0] <= 8'd136) &&
      (m_axis_tdata_o[11:8] >= 4'd1) && (m_axis_tdata_o[11:8] <= 4'd12) &&
      (m_axis_tdata_o[16:12] != 5'd0))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[21:17] <= 5'd23) &&
      (m_axis_tdata_o[27:22] <= 6'd59) && (m_axis_tdata_o[33:28] <= 6'd59))
    else $error("time field out of range");

endmodule

`default_nettype wire

[src/s2cd_dp.sv]
`default_nettype none

module s2cd_dp
  import s2cd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic [InW-1:0]  in_data_i,
  input  wire cmd_t            cmd_i,
  output      sts_t            sts_o,
  output      logic [OutW-1:0] result_o
);

  logic [31:0] secs_q, secs_d;
  logic [15:0] days_q, days_d;
  logic [16:0] rem_q, rem_d;
  logic [7:0]  year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;

  logic [50:0] day_prod;
  logic [31:0] day_secs;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [25:0] hour_prod;
  logic [19:0] min_prod;
  logic [16:0] hour_secs;
  logic [16:0] min_secs;

  assign leap = is_leap(year_q);
  assign ylen = year_days(leap);
  assign mlen = month_days(month_q, leap);

  assign sts_o.year_done  = days_q < {7'd0, ylen};
  assign sts_o.month_done = (month_q == MonthDec) || (days_q < {11'd0, mlen});

  // 86400 = 128 * 675: drop the power of two, then multiply by the reciprocal of 675
  assign day_prod = {26'd0, secs_q[31:7]} * {25'd0, DayRecip};
  assign day_secs = {16'd0, days_q} * 32'(SecsPerDay);

  // 3600 = 16 * 225 and 60 = 4 * 15, split the same way
  assign hour_prod = {13'd0, rem_q[16:4]} * {12'd0, HourRecip};
  assign min_prod  = {10'd0, rem_q[11:2]} * {9'd0, MinRecip};
  assign hour_secs = {12'd0, hour_q} * 17'(SecsPerHour);
  assign min_secs  = {11'd0, min_q} * 17'(SecsPerMin);

  always_comb begin
    secs_d  = secs_q;
    days_d  = days_q;
    rem_d   = rem_q;
    year_d  = year_q;
    month_d = month_q;
    hour_d  = hour_q;
    min_d   = min_q;
    if (cmd_i.load) begin
      secs_d  = in_data_i;
      rem_d   = '0;
      year_d  = '0;
      month_d = MonthJan;
      hour_d  = '0;
      min_d   = '0;
    end else if (cmd_i.day_step) begin
      days_d = day_prod[50:35];
    end else if (cmd_i.day_sub) begin
      rem_d = 17'(secs_q - day_secs);
    end else if (cmd_i.year_step) begin
      days_d = days_q - {7'd0, ylen};
      year_d = year_q + 8'd1;
    end else if (cmd_i.month_step) begin
      days_d  = days_q - {11'd0, mlen};
      month_d = month_q + 4'd1;
    end else if (cmd_i.hour_step) begin
      hour_d = hour_prod[25:21];
    end else if (cmd_i.hour_sub) begin
      rem_d = rem_q - hour_secs;
    end else if (cmd_i.min_step) begin
      min_d = min_prod[19:14];
    end else if (cmd_i.min_sub) begin
      rem_d = rem_q - min_secs;
    end
  end

  always_ff @(posedge clk_i) begin
    secs_q  <= secs_d;
    days_q  <= days_d;
    rem_q   <= rem_d;
    year_q  <= year_d;
    month_q <= month_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
  end

  // year, month, day, hour, minute, second from the lowest bit up
  assign result_o = {6'd0, rem_q[5:0], min_q, hour_q, days_q[4:0] + 5'd1, month_q, year_q};

endmodule

`default_nettype wire

[src/s2cd_ctrl.sv]
`default_nettype none

module s2cd_ctrl
  import s2cd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o,
  input  wire logic out_free_i,
  output      logic out_push_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY,
    ST_DAY_SUB,
    ST_YEAR,
    ST_MONTH,
    ST_HOUR,
    ST_HOUR_SUB,
    ST_MIN,
    ST_MIN_SUB,
    ST_DONE
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_push_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DAY:      cmd_o.day_step   = 1'b1;
      ST_DAY_SUB:  cmd_o.day_sub    = 1'b1;
      ST_YEAR:     cmd_o.year_step  = !sts_i.year_done;
      ST_MONTH:    cmd_o.month_step = !sts_i.month_done;
      ST_HOUR:     cmd_o.hour_step  = 1'b1;
      ST_HOUR_SUB: cmd_o.hour_sub   = 1'b1;
      ST_MIN:      cmd_o.min_step   = 1'b1;
      ST_MIN_SUB:  cmd_o.min_sub    = 1'b1;
      ST_DONE:     out_push_o       = out_free_i;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DAY;
          end
        end
        ST_DAY:     state_q <= ST_DAY_SUB;
        ST_DAY_SUB: state_q <= ST_YEAR;
        ST_YEAR: begin
          if (sts_i.year_done) begin
            state_q <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (sts_i.month_done) begin
            state_q <= ST_HOUR;
          end
        end
        ST_HOUR:     state_q <= ST_HOUR_SUB;
        ST_HOUR_SUB: state_q <= ST_MIN;
        ST_MIN:      state_q <= ST_MIN_SUB;
        ST_MIN_SUB:  state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/s2cd_out_reg.sv]
`default_nettype none

module s2cd_out_reg
  import s2cd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire logic [OutW-1:0] data_i,
  output      logic            free_o,
  output      logic            m_axis_tvalid_o,
  input  wire logic            m_axis_tready_i,
  output      logic [OutW-1:0] m_axis_tdata_o
);

  logic            valid_q;
  logic [OutW-1:0] data_q;

  assign free_o          = !valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  // hold the payload while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

[tb/tb_seconds_to_calendar_date.sv]
module tb_seconds_to_calendar_date;
  import s2cd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 6000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned DaysTo2100  = 36525;
  localparam int unsigned MaxDay      = 49709;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
  } date_t;

  localparam int unsigned MonthLen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid_i;
  logic            s_axis_tready_o;
  logic [InW-1:0]  s_axis_tdata_i;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i;
  logic [OutW-1:0] m_axis_tdata_o;

  logic [31:0] seconds_q [$];
  date_t       dates_due [$];
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          in_fire;

  seconds_to_calendar_date uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit gregorian_leap(int unsigned offset);
    int unsigned yr;
    yr = 2000 + offset;
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic date_t calendar_of(logic [31:0] secs);
    date_t       d;
    int unsigned days;
    int unsigned rem;
    int unsigned yr;
    int unsigned mon;
    int unsigned len;
    days = secs / SecsPerDay;
    rem  = secs % SecsPerDay;
    yr   = 0;
    mon  = 1;
    // walk whole years, then whole months
    while (1) begin
      len = gregorian_leap(yr) ? 366 : 365;
      if (days < len) break;
      days -= len;
      yr++;
    end
    while (mon < 12) begin
      len = MonthLen[mon - 1];
      if (mon == 2 && gregorian_leap(yr)) len = 29;
      if (days < len) break;
      days -= len;
      mon++;
    end
    d.year   = yr[7:0];
    d.month  = mon[3:0];
    d.day    = 5'(days + 1);
    d.hour   = 5'(rem / SecsPerHour);
    d.minute = 6'((rem % SecsPerHour) / SecsPerMin);
    d.second = 6'(rem % SecsPerMin);
    return d;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < MaxReports) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  // Sender and receiver: change at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= receiver_idle_pct);
      if (!s_axis_tvalid_i || in_fire) begin
        if (seconds_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= seconds_q.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Record accepted inputs and check results at the rising edge
  always @(posedge clk_i) begin
    date_t got;
    date_t want;
    in_fire = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_fire = 1'b1;
        dates_due.push_back(calendar_of(s_axis_tdata_i));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.year   = m_axis_tdata_o[7:0];
        got.month  = m_axis_tdata_o[11:8];
        got.day    = m_axis_tdata_o[16:12];
        got.hour   = m_axis_tdata_o[21:17];
        got.minute = m_axis_tdata_o[27:22];
        got.second = m_axis_tdata_o[33:28];
        if (dates_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_axis_tdata_o));
        end else begin
          want = dates_due.pop_front();
          check_field("year_offset", got.year, want.year);
          check_field("month_number", got.month, want.month);
          check_field("day_of_month", got.day, want.day);
          check_field("hour_of_day", got.hour, want.hour);
          check_field("minute_of_hour", got.minute, want.minute);
          check_field("second_of_minute", got.second, want.second);
        end
      end
    end
  end

  // Abort when no transaction happens on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_seconds_to_calendar_date: done, errors");
        $finish;
      end
    end
  end

  task automatic queue_directed();
    int unsigned d2100;
    d2100 = DaysTo2100 * SecsPerDay;
    seconds_q.push_back(32'd0);
    seconds_q.push_back(32'd59);
    seconds_q.push_back(32'd60);
    seconds_q.push_back(32'd3599);
    seconds_q.push_back(32'd3600);
    seconds_q.push_back(SecsPerDay - 1);
    seconds_q.push_back(SecsPerDay);
    seconds_q.push_back(58 * SecsPerDay + 43199);    // 2000-02-28 11:59:59
    seconds_q.push_back(59 * SecsPerDay);            // 2000-02-29, leap day
    seconds_q.push_back(60 * SecsPerDay);            // 2000-03-01
    seconds_q.push_back(366 * SecsPerDay - 1);       // last second of 2000
    seconds_q.push_back(366 * SecsPerDay);           // first second of 2001
    seconds_q.push_back((366 + 59) * SecsPerDay);    // 2001-03-01, no leap day
    seconds_q.push_back((4 * 365 + 1 + 59) * SecsPerDay); // 2004-02-29
    seconds_q.push_back(d2100 - 1);                  // end of 2099
    seconds_q.push_back(d2100);                      // start of 2100
    seconds_q.push_back(d2100 + 58 * SecsPerDay);    // 2100-02-28
    seconds_q.push_back(d2100 + 59 * SecsPerDay);    // 2100-03-01, century not leap
    seconds_q.push_back(d2100 + 364 * SecsPerDay + SecsPerDay - 1);
    seconds_q.push_back(32'hAAAA_AAAA);
    seconds_q.push_back(32'h5555_5555);
    seconds_q.push_back(32'hFFFF_FFFF);
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned day;
    repeat (count) begin
      case ($urandom_range(3))
        0: begin
          // land on or next to a day boundary
          day = $urandom_range(MaxDay);
          seconds_q.push_back(day * SecsPerDay + ($urandom_range(1) ? 0 : SecsPerDay - 1));
        end
        1: begin
          day = $urandom_range(DaysTo2100 + 400, DaysTo2100 - 400);
          seconds_q.push_back(day * SecsPerDay + $urandom_range(SecsPerDay - 1));
        end
        default: seconds_q.push_back($urandom);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (seconds_q.size() != 0 || s_axis_tvalid_i || dates_due.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    s_axis_tvalid_i   = 1'b0;
    s_axis_tdata_i    = '0;
    m_axis_tready_i   = 1'b0;
    mismatches        = 0;
    quiet_cycles      = 0;
    in_fire           = 1'b0;
    sender_idle_pct   = 38;
    receiver_idle_pct = 74;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_directed();
    queue_random(230);
    wait_drained();

    sender_idle_pct   = 74;
    receiver_idle_pct = 38;
    queue_random(250);
    wait_drained();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    queue_directed();
    queue_random(230);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && dates_due.size() == 0) begin
      $display("tb_seconds_to_calendar_date: done, clean");
    end else begin
      if (dates_due.size() != 0) report_mismatch("results still outstanding");
      $display("tb_seconds_to_calendar_date: done, errors");
    end
    $finish;
  end

endmodule

[seconds_to_calendar_date.f]
src/s2cd_pkg.sv
src/s2cd_dp.sv
src/s2cd_ctrl.sv
src/s2cd_out_reg.sv
src/seconds_to_calendar_date.sv
tb/tb_seconds_to_calendar_date.sv
